[src/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// Types and fixed constants shared by the triangle unit normal blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tun_pkg;

  localparam int FIELD_BITS = 16;
  localparam int NORM_BITS  = 30;
  localparam int NORM_POS   = 29;
  localparam int SHIFT_BITS = 6;
  localparam int ROOT_BITS  = 31;
  localparam int SQ_BITS    = 64;
  localparam int Q_DEPTH    = 4;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] vertex_a_x;
    logic signed [FIELD_BITS-1:0] vertex_a_y;
    logic signed [FIELD_BITS-1:0] vertex_a_z;
    logic signed [FIELD_BITS-1:0] vertex_b_x;
    logic signed [FIELD_BITS-1:0] vertex_b_y;
    logic signed [FIELD_BITS-1:0] vertex_b_z;
    logic signed [FIELD_BITS-1:0] vertex_c_x;
    logic signed [FIELD_BITS-1:0] vertex_c_y;
    logic signed [FIELD_BITS-1:0] vertex_c_z;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] normal_x;
    logic signed [FIELD_BITS-1:0] normal_y;
    logic signed [FIELD_BITS-1:0] normal_z;
    logic                         degenerate;
  } out_t;

  typedef struct packed {
    logic                           deg;
    logic [2:0]                     neg;
    logic [2:0][NORM_BITS-1:0]      mag;
  } norm_t;

endpackage

[src/tun_front.sv]
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, exact cross product, magnitude/sign split and normalization.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_front #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tun_pkg::in_t  in_data,
  output logic          push,
  output tun_pkg::norm_t push_data,
  input  logic          q_full
);

  localparam int D  = COORD_BITS + 1;
  localparam int UW = 2 * D;
  localparam int PW = $clog2(UW);
  localparam int WW = UW + tun_pkg::NORM_BITS;

  logic en;

  logic                v1, v2, v3, v4;
  logic signed [D-1:0] e1 [3];
  logic signed [D-1:0] e2 [3];
  logic signed [UW-1:0] p [6];
  logic [2:0][UW-1:0]  u3;
  logic [2:0]          neg3;
  logic [UW-1:0]       or3;
  logic [2:0][UW-1:0]  u4;
  logic [2:0]          neg4;
  logic                deg4;
  logic [PW-1:0]       pos4;
  logic [PW-1:0]       pos_next;

  logic signed [D-1:0] va [3];
  logic signed [D-1:0] vb [3];
  logic signed [D-1:0] vc [3];
  logic signed [UW:0]  n [3];

  assign en       = !q_full || !v4;
  assign in_ready = en;

  assign va[0] = $signed({in_data.vertex_a_x[COORD_BITS-1], in_data.vertex_a_x[COORD_BITS-1:0]});
  assign va[1] = $signed({in_data.vertex_a_y[COORD_BITS-1], in_data.vertex_a_y[COORD_BITS-1:0]});
  assign va[2] = $signed({in_data.vertex_a_z[COORD_BITS-1], in_data.vertex_a_z[COORD_BITS-1:0]});
  assign vb[0] = $signed({in_data.vertex_b_x[COORD_BITS-1], in_data.vertex_b_x[COORD_BITS-1:0]});
  assign vb[1] = $signed({in_data.vertex_b_y[COORD_BITS-1], in_data.vertex_b_y[COORD_BITS-1:0]});
  assign vb[2] = $signed({in_data.vertex_b_z[COORD_BITS-1], in_data.vertex_b_z[COORD_BITS-1:0]});
  assign vc[0] = $signed({in_data.vertex_c_x[COORD_BITS-1], in_data.vertex_c_x[COORD_BITS-1:0]});
  assign vc[1] = $signed({in_data.vertex_c_y[COORD_BITS-1], in_data.vertex_c_y[COORD_BITS-1:0]});
  assign vc[2] = $signed({in_data.vertex_c_z[COORD_BITS-1], in_data.vertex_c_z[COORD_BITS-1:0]});

  always_comb begin
    n[0] = {p[0][UW-1], p[0]} - {p[1][UW-1], p[1]};
    n[1] = {p[2][UW-1], p[2]} - {p[3][UW-1], p[3]};
    n[2] = {p[4][UW-1], p[4]} - {p[5][UW-1], p[5]};
  end

  always_comb begin
    pos_next = '0;
    for (int i = 0; i < UW; i++) begin
      if (or3[i]) begin
        pos_next = PW'(i);
      end
    end
  end

  always_comb begin
    logic [WW-1:0]                  ext;
    logic [WW-1:0]                  sh;
    logic [tun_pkg::SHIFT_BITS-1:0] amt;
    push_data.deg = deg4;
    push_data.neg = neg4;
    for (int i = 0; i < 3; i++) begin
      ext = {{tun_pkg::NORM_BITS{1'b0}}, u4[i]};
      if (tun_pkg::SHIFT_BITS'(pos4) >= tun_pkg::SHIFT_BITS'(tun_pkg::NORM_POS)) begin
        amt = tun_pkg::SHIFT_BITS'(pos4) - tun_pkg::SHIFT_BITS'(tun_pkg::NORM_POS);
        sh  = ext >> amt;
      end else begin
        amt = tun_pkg::SHIFT_BITS'(tun_pkg::NORM_POS) - tun_pkg::SHIFT_BITS'(pos4);
        sh  = ext << amt;
      end
      push_data.mag[i] = sh[tun_pkg::NORM_BITS-1:0];
    end
  end

  assign push = en && v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= vb[i] - va[i];
        e2[i] <= vc[i] - va[i];
      end
      p[0] <= e1[1] * e2[2];
      p[1] <= e1[2] * e2[1];
      p[2] <= e1[2] * e2[0];
      p[3] <= e1[0] * e2[2];
      p[4] <= e1[0] * e2[1];
      p[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= n[i][UW];
        u3[i]   <= n[i][UW] ? UW'(-n[i]) : UW'(n[i]);
      end
      or3  <= (n[0][UW] ? UW'(-n[0]) : UW'(n[0])) | (n[1][UW] ? UW'(-n[1]) : UW'(n[1]))
            | (n[2][UW] ? UW'(-n[2]) : UW'(n[2]));
      u4   <= u3;
      neg4 <= neg3;
      deg4 <= (or3 == '0);
      pos4 <= pos_next;
    end
  end

endmodule

[src/tun_queue.sv]
// ----------------------------------------------------------------------------
// tun_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tun_pkg::norm_t push_data,
  input  logic           pop,
  output tun_pkg::norm_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int AW = $clog2(tun_pkg::Q_DEPTH);

  tun_pkg::norm_t mem [tun_pkg::Q_DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full     = (count == (AW+1)'(tun_pkg::Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(tun_pkg::Q_DEPTH))
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance");

endmodule

[src/tun_back.sv]
// ----------------------------------------------------------------------------
// tun_back
// Sum of squares, pipelined square root, pipelined rounded division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tun_back #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  tun_pkg::norm_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output tun_pkg::out_t  out_data
);

  localparam int NB = tun_pkg::NORM_BITS;
  localparam int RB = tun_pkg::ROOT_BITS;
  localparam int SW = tun_pkg::SQ_BITS;
  localparam int F  = OUT_FRAC_BITS;
  localparam int QW = F + 1;
  localparam int NW = NB + F + 1;
  localparam int XW = (QW > tun_pkg::FIELD_BITS) ? QW : tun_pkg::FIELD_BITS;

  logic en;

  logic               v0, v1;
  tun_pkg::norm_t     it0, it1;
  logic [2*NB-1:0]    sqr [3];

  logic               sq_v    [RB+1];
  tun_pkg::norm_t     sq_item [RB+1];
  logic [SW-1:0]      sq_rem  [RB+1];
  logic [RB-1:0]      sq_root [RB+1];

  logic               dv_v    [QW+1];
  tun_pkg::norm_t     dv_item [QW+1];
  logic [RB-1:0]      dv_len  [QW+1];
  logic [2:0][RB-1:0] dv_rem  [QW+1];
  logic [2:0][QW-1:0] dv_low  [QW+1];
  logic [2:0][QW-1:0] dv_quo  [QW+1];

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      v0 <= pop;
      v1 <= v0;
      sq_v[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= q_data;
      it1 <= it0;
      for (int i = 0; i < 3; i++) begin
        sqr[i] <= it0.mag[i] * it0.mag[i];
      end
      sq_item[0] <= it1;
      sq_rem[0]  <= SW'(sqr[0]) + SW'(sqr[1]) + SW'(sqr[2]);
      sq_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    localparam int K = RB - 1 - j;
    logic [SW-1:0] trial;
    assign trial = (SW'(sq_root[j]) << (K + 1)) | (SW'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_item[j+1] <= sq_item[j];
        if (sq_rem[j] >= trial) begin
          sq_rem[j+1]  <= sq_rem[j] - trial;
          sq_root[j+1] <= sq_root[j] | (RB'(1) << K);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [NW-1:0] num;
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[RB];
    end
    if (en) begin
      dv_item[0] <= sq_item[RB];
      dv_len[0]  <= sq_root[RB];
      for (int i = 0; i < 3; i++) begin
        num = {sq_item[RB].mag[i], {F{1'b0}}} + NW'(sq_root[RB] >> 1);
        dv_rem[0][i] <= RB'(num[NW-1:QW]);
        dv_low[0][i] <= num[QW-1:0];
        dv_quo[0][i] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk) begin
      logic [RB:0] r2;
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (en) begin
        dv_v[j+1] <= dv_v[j];
      end
      if (en) begin
        dv_item[j+1] <= dv_item[j];
        dv_len[j+1]  <= dv_len[j];
        dv_low[j+1]  <= dv_low[j];
        for (int i = 0; i < 3; i++) begin
          r2 = {dv_rem[j][i], dv_low[j][i][QW-1-j]};
          if (r2 >= {1'b0, dv_len[j]}) begin
            dv_rem[j+1][i] <= RB'(r2 - {1'b0, dv_len[j]});
            dv_quo[j+1][i] <= {dv_quo[j][i][QW-2:0], 1'b1};
          end else begin
            dv_rem[j+1][i] <= RB'(r2);
            dv_quo[j+1][i] <= {dv_quo[j][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [2:0][tun_pkg::FIELD_BITS-1:0] comp;

  always_comb begin
    logic [XW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = XW'(dv_quo[QW][i]);
      if (q > (XW'(1) << F)) begin
        q = XW'(1) << F;
      end
      if (dv_item[QW].neg[i]) begin
        q = -q;
      end
      comp[i] = dv_item[QW].deg ? '0 : q[tun_pkg::FIELD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.normal_x   <= comp[0];
      out_data.normal_y   <= comp[1];
      out_data.normal_z   <= comp[2];
      out_data.degenerate <= dv_item[QW].deg;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0))
    else $error("degenerate result with nonzero normal");
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    (sq_v[RB] && !sq_item[RB].deg) |-> (sq_root[RB] != '0))
    else $error("zero length for a nondegenerate normal");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

[src/triangle_unit_normal_core.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// Unit normal of a 3D triangle in signed fixed point.
// ----------------------------------------------------------------------------
// Accepts one triangle per clock while in_ready is high and returns one
// result per triangle in order. A front pipeline of four stages forms the
// edges, the exact cross product and its normalized magnitudes; a four-entry
// queue decouples it from the back pipeline, which squares, sums, takes a
// one-bit-per-stage square root (31 stages) and runs three restoring
// dividers of OUT_FRAC_BITS+1 stages. A zero cross product gives zero
// components with degenerate set.
`timescale 1ns / 1ps

module triangle_unit_normal_core #(
  parameter int COORD_BITS    = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tun_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tun_pkg::out_t out_data
);

  logic           push, pop, q_full, q_empty;
  tun_pkg::norm_t push_data, pop_data;

  tun_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tun_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tun_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
